FILE: design/dmpp_pkg.sv
// Package for the dual motor position PID: payload types, sequencer states,
// register indexes, reset values and the multiply unit request.
// No dependencies.
package dmpp_pkg;

    localparam int GainW = 40;
    localparam int AccW  = 96;
    localparam int XW    = 64;

    localparam logic [1:0] CFG_GAIN_P     = 2'd0;
    localparam logic [1:0] CFG_GAIN_I     = 2'd1;
    localparam logic [1:0] CFG_GAIN_D     = 2'd2;
    localparam logic [1:0] CFG_MAX_SIGNAL = 2'd3;

    localparam logic [39:0] GAIN_P_RST = 40'd33554432;
    localparam logic [39:0] GAIN_I_RST = 40'd839;
    localparam logic [39:0] GAIN_D_RST = 40'd3355443200;
    localparam logic [7:0]  MAX_SIG_RST = 8'd80;

    typedef struct packed {
        logic signed [31:0] position_left;
        logic signed [31:0] position_right;
        logic signed [31:0] target_left;
        logic signed [31:0] target_right;
        logic [15:0]        elapsed_ms;
        logic               clear_history;
    } t_in_item;

    typedef struct packed {
        logic       dir_left;
        logic [7:0] speed_left;
        logic       dir_right;
        logic [7:0] speed_right;
    } t_out_item;

    typedef struct packed {
        logic go;
        logic clr;
    } t_mac_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mac_sts;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_MUL_PE,
        S_INTEG,
        S_MUL_IE,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_MAG,
        S_LIMIT,
        S_DIV,
        S_NEXT,
        S_OUT
    } t_state;

endpackage

FILE: design/dmpp_in_if.sv
// Request channel carrying one control tick.
// Depends on dmpp_pkg.
interface dmpp_in_if;
    logic               valid;
    logic               ready;
    dmpp_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/dmpp_out_if.sv
// Result channel carrying both motor drives.
// Depends on dmpp_pkg.
interface dmpp_out_if;
    logic                valid;
    logic                ready;
    dmpp_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/dmpp_mac.sv
// Shared multiply-accumulate: 40-bit signed operand times 64-bit signed operand,
// one 16-bit slice per cycle into a 96-bit accumulator.
// Depends on dmpp_pkg.
module dmpp_mac (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dmpp_pkg::t_mac_req        i_req,
    input  logic signed [39:0]        i_a,
    input  logic signed [63:0]        i_x,
    output dmpp_pkg::t_mac_sts        o_sts,
    output logic signed [95:0]        o_acc
);
    logic              r_busy;
    logic [1:0]        r_idx;
    logic signed [95:0] r_acc;
    logic signed [16:0] w_chunk;
    logic signed [56:0] w_pp;
    logic signed [95:0] w_term;

    always_comb begin
        unique case (r_idx)
            2'd0: w_chunk = {1'b0, i_x[15:0]};
            2'd1: w_chunk = {1'b0, i_x[31:16]};
            2'd2: w_chunk = {1'b0, i_x[47:32]};
            default: w_chunk = {i_x[63], i_x[63:48]};
        endcase
        w_pp   = i_a * w_chunk;
        w_term = {{39{w_pp[56]}}, w_pp} << {r_idx, 4'b0000};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (i_req.go && !r_busy) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (r_busy) begin
            r_idx <= r_idx + 2'd1;
            if (r_idx == 2'd3) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go && !r_busy) begin
            if (i_req.clr) begin
                r_acc <= '0;
            end
        end else if (r_busy) begin
            r_acc <= r_acc + w_term;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_busy && (r_idx == 2'd3);
    assign o_acc      = r_acc;

endmodule

FILE: design/dual_motor_position_pid.sv
// Dual motor position PID: sequencer around one shared multiply-accumulate unit.
// Depends on dmpp_pkg, dmpp_in_if, dmpp_out_if, dmpp_mac.
// Each motor takes five passes through the shared multiplier plus up to 8 restoring
// quotient steps. Not ready while a request is in progress, and the final step waits
// while the previous result is still unaccepted.
// Reset (synchronous, active low): gains to defaults, histories cleared, idle.
module dual_motor_position_pid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [39:0]       i_cfg_data,
    dmpp_in_if.sink           i_in,
    dmpp_out_if.source        o_out
);
    dmpp_pkg::t_state    r_state, n_state;
    dmpp_pkg::t_mac_req  w_req;
    dmpp_pkg::t_mac_sts  w_sts;
    dmpp_pkg::t_in_item  r_item;
    dmpp_pkg::t_out_item r_out;

    logic signed [39:0] r_gp, r_gi, r_gd;
    logic [7:0]         r_max;
    logic signed [31:0] r_prev [2];
    logic signed [31:0] r_integ [2];

    logic [15:0]        r_el;
    logic               r_m;
    logic signed [31:0] r_err;
    logic signed [32:0] r_diff;
    logic signed [47:0] r_pe, r_ie;
    logic [95:0]        r_mag;
    logic [47:0]        r_limit;
    logic [39:0]        r_den;
    logic [2:0]         r_k;
    logic [7:0]         r_q;
    logic               r_sat, r_dir, r_dl;
    logic [7:0]         r_sl;
    logic               r_ovalid;

    logic signed [39:0] w_a;
    logic signed [63:0] w_x;
    logic signed [95:0] w_acc;
    logic signed [31:0] w_err;
    logic signed [49:0] w_sum;
    logic signed [31:0] w_sat;
    logic [47:0]        w_dsub;
    logic               w_ge;
    logic [7:0]         w_speed;
    logic               w_in_ready;
    logic               w_out_free;

    dmpp_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_a),
        .i_x     (w_x),
        .o_sts   (w_sts),
        .o_acc   (w_acc)
    );

    assign w_out_free = !r_ovalid || o_out.ready;

    always_comb begin
        w_err = r_m ? (r_item.position_right - r_item.target_right)
                    : (r_item.position_left - r_item.target_left);
        w_sum = {{18{r_integ[r_m][31]}}, r_integ[r_m]} + {{2{w_acc[47]}}, w_acc[47:0]};
        if (!w_sum[49] && (|w_sum[48:31])) begin
            w_sat = 32'sh7FFF_FFFF;
        end else if (w_sum[49] && !(&w_sum[48:31])) begin
            w_sat = 32'sh8000_0000;
        end else begin
            w_sat = w_sum[31:0];
        end
        w_dsub  = {8'd0, r_den} << r_k;
        w_ge    = r_mag[47:0] >= w_dsub;
        w_speed = r_sat ? r_max : r_q;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dmpp_pkg::S_IDLE:   if (i_in.valid) n_state = dmpp_pkg::S_ERR;
            dmpp_pkg::S_ERR:    n_state = dmpp_pkg::S_MUL_PE;
            dmpp_pkg::S_MUL_PE: if (w_sts.done) n_state = dmpp_pkg::S_INTEG;
            dmpp_pkg::S_INTEG:  n_state = dmpp_pkg::S_MUL_IE;
            dmpp_pkg::S_MUL_IE: if (w_sts.done) n_state = dmpp_pkg::S_MUL_P;
            dmpp_pkg::S_MUL_P:  if (w_sts.done) n_state = dmpp_pkg::S_MUL_I;
            dmpp_pkg::S_MUL_I:  if (w_sts.done) n_state = dmpp_pkg::S_MUL_D;
            dmpp_pkg::S_MUL_D:  if (w_sts.done) n_state = dmpp_pkg::S_MAG;
            dmpp_pkg::S_MAG:    n_state = dmpp_pkg::S_LIMIT;
            dmpp_pkg::S_LIMIT:  n_state = (r_mag >= {48'd0, r_limit}) ? dmpp_pkg::S_NEXT
                                                                      : dmpp_pkg::S_DIV;
            dmpp_pkg::S_DIV:    if (r_k == 3'd0) n_state = dmpp_pkg::S_NEXT;
            dmpp_pkg::S_NEXT:   n_state = r_m ? dmpp_pkg::S_OUT : dmpp_pkg::S_ERR;
            dmpp_pkg::S_OUT:    if (w_out_free) n_state = dmpp_pkg::S_IDLE;
            default:            n_state = dmpp_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_in_ready = 1'b0;
        w_req.go   = 1'b0;
        w_req.clr  = 1'b0;
        w_a        = '0;
        w_x        = '0;
        unique case (r_state)
            dmpp_pkg::S_IDLE: w_in_ready = 1'b1;
            dmpp_pkg::S_MUL_PE: begin
                w_req.go  = !w_sts.busy;
                w_req.clr = 1'b1;
                w_a       = {{8{r_err[31]}}, r_err};
                w_x       = {48'd0, r_el};
            end
            dmpp_pkg::S_MUL_IE: begin
                w_req.go  = !w_sts.busy;
                w_req.clr = 1'b1;
                w_a       = {{8{r_integ[r_m][31]}}, r_integ[r_m]};
                w_x       = {48'd0, r_el};
            end
            dmpp_pkg::S_MUL_P: begin
                w_req.go  = !w_sts.busy;
                w_req.clr = 1'b1;
                w_a       = r_gp;
                w_x       = {{16{r_pe[47]}}, r_pe};
            end
            dmpp_pkg::S_MUL_I: begin
                w_req.go = !w_sts.busy;
                w_a      = r_gi;
                w_x      = {{16{r_ie[47]}}, r_ie};
            end
            dmpp_pkg::S_MUL_D: begin
                w_req.go = !w_sts.busy;
                w_a      = r_gd;
                w_x      = {{31{r_diff[32]}}, r_diff};
            end
            default: begin
            end
        endcase
    end

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dmpp_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_gp     <= dmpp_pkg::GAIN_P_RST;
            r_gi     <= dmpp_pkg::GAIN_I_RST;
            r_gd     <= dmpp_pkg::GAIN_D_RST;
            r_max    <= dmpp_pkg::MAX_SIG_RST;
            r_prev   <= '{default: '0};
            r_integ  <= '{default: '0};
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    dmpp_pkg::CFG_GAIN_P:     r_gp  <= i_cfg_data;
                    dmpp_pkg::CFG_GAIN_I:     r_gi  <= i_cfg_data;
                    dmpp_pkg::CFG_GAIN_D:     r_gd  <= i_cfg_data;
                    dmpp_pkg::CFG_MAX_SIGNAL: r_max <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            if (r_state == dmpp_pkg::S_IDLE && i_in.valid && i_in.data.clear_history) begin
                r_prev  <= '{default: '0};
                r_integ <= '{default: '0};
            end
            if (r_state == dmpp_pkg::S_INTEG) begin
                r_integ[r_m] <= w_sat;
                r_prev[r_m]  <= r_err;
            end
            if (r_state == dmpp_pkg::S_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            dmpp_pkg::S_IDLE: begin
                r_item <= i_in.data;
                r_el   <= (i_in.data.elapsed_ms == 16'd0) ? 16'd1 : i_in.data.elapsed_ms;
                r_m    <= 1'b0;
            end
            dmpp_pkg::S_ERR: begin
                r_err  <= w_err;
                r_diff <= {w_err[31], w_err} - {r_prev[r_m][31], r_prev[r_m]};
            end
            dmpp_pkg::S_INTEG: r_pe <= w_acc[47:0];
            dmpp_pkg::S_MUL_P: if (!w_sts.busy) r_ie <= w_acc[47:0];
            dmpp_pkg::S_MAG: begin
                r_dir   <= !w_acc[95] && (w_acc != '0);
                r_mag   <= w_acc[95] ? 96'(-w_acc) : w_acc;
                r_limit <= {24'(r_max) * 24'(r_el), 24'd0};
                r_den   <= {r_el, 24'd0};
                r_k     <= 3'd7;
                r_q     <= 8'd0;
                r_sat   <= 1'b0;
            end
            dmpp_pkg::S_LIMIT: r_sat <= r_mag >= {48'd0, r_limit};
            dmpp_pkg::S_DIV: begin
                if (w_ge) begin
                    r_mag[47:0] <= r_mag[47:0] - w_dsub;
                end
                r_q <= {r_q[6:0], w_ge};
                r_k <= r_k - 3'd1;
            end
            dmpp_pkg::S_NEXT: begin
                if (!r_m) begin
                    r_m  <= 1'b1;
                    r_dl <= r_dir;
                    r_sl <= w_speed;
                end
            end
            dmpp_pkg::S_OUT: begin
                if (w_out_free) begin
                    r_out.dir_left    <= r_dl;
                    r_out.speed_left  <= r_sl;
                    r_out.dir_right   <= r_dir;
                    r_out.speed_right <= w_speed;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
